// ----- sv/jmpp_pkg.sv -----
// shared types, constants and arithmetic helpers of the joint motion profile block
package jmpp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int TIME_W     = WORD_BITS - 1;
    localparam int MAG_W      = WORD_BITS + 3;
    localparam int NUM_W      = WORD_BITS + FRAC_BITS;
    localparam int REM_W      = WORD_BITS;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int SQB        = (WORD_BITS + FRAC_BITS + 5) / 2;
    localparam int F_W        = FRAC_BITS + 4;
    localparam int SUM_W      = MAG_W + 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [MAG_W-1:0] BIGV    = MAG_W'(1) << (WORD_BITS + 2);
    localparam logic [SQB:0]     SQ_LIM  = (SQB + 1)'(1) << SQB;
    localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VEL    = 3'd6;

    localparam logic [1:0] SEG_HOLD   = 2'd0;
    localparam logic [1:0] SEG_ACCEL  = 2'd1;
    localparam logic [1:0] SEG_CRUISE = 2'd2;
    localparam logic [1:0] SEG_DECEL  = 2'd3;

    typedef enum logic [2:0] {
        CFG_LOAD,
        CFG_DIV_TC,
        CFG_DIV_Q2,
        CFG_FINISH,
        CFG_IDLE
    } cfg_state_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] sample_time;
        logic signed [WORD_BITS-1:0] hold_position;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] position;
        logic [1:0]                  segment;
    } out_item_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] start_position;
        logic signed [WORD_BITS-1:0] move_distance;
        logic signed [WORD_BITS-1:0] end_position;
        logic [TIME_W-1:0]           switch_time;
        logic [TIME_W-1:0]           final_time;
        logic [TIME_W-1:0]           accel_max;
        logic [TIME_W-1:0]           vel_max;
        logic [MAG_W-1:0]            tc;
        logic [MAG_W-1:0]            q2;
        logic [MAG_W:0]              tf2;
        logic [MAG_W-1:0]            k_cruise;
        logic                        tri_mode;
        logic                        busy;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] hold;
        logic [1:0]                  seg;
        logic                        tri_mode;
        logic [SQB:0]                t_sq;
        logic [SQB:0]                w_sq;
        logic [TIME_W-1:0]           ts;
    } side_t;

    // (a*b) >> FRAC_BITS on magnitudes, saturating at BIGV
    function automatic logic [MAG_W-1:0] mul_sat(input logic [MAG_W:0] a,
                                                 input logic [MAG_W:0] b);
        logic [2*MAG_W+1:0]           p;
        logic [2*MAG_W+1-FRAC_BITS:0] r;
        p = a * b;
        r = p[2*MAG_W+1:FRAC_BITS];
        if (r > (2*MAG_W+2-FRAC_BITS)'(BIGV))
            mul_sat = BIGV;
        else
            mul_sat = r[MAG_W-1:0];
    endfunction

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [REM_W:0] div_try(input logic [REM_W-1:0] r,
                                               input logic nb,
                                               input logic [TIME_W-1:0] b);
        logic [REM_W:0] s;
        logic [REM_W:0] bb;
        s  = {r, nb};
        bb = (REM_W + 1)'(b);
        if (s >= bb)
            div_try = {1'b1, REM_W'(s - bb)};
        else
            div_try = {1'b0, s[REM_W-1:0]};
    endfunction

    function automatic logic [MAG_W-1:0] clamp_q(input logic [NUM_W-1:0] q);
        if (q > NUM_W'(BIGV))
            clamp_q = BIGV;
        else
            clamp_q = q[MAG_W-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] umag(input logic signed [WORD_BITS-1:0] x);
        if (x[WORD_BITS-1])
            umag = WORD_BITS'(-x);
        else
            umag = WORD_BITS'(x);
    endfunction

endpackage

// ----- sv/joint_motion_profile_position.sv -----
// top level: trapezoidal / triangular joint position profile, pipelined per sample
// Accepts one sample per cycle while the output is not stalled and no recompute is
// running, and passes it through the pipelined time divider, two quotient bits per
// stage, followed by two multiplier stages, a select stage and the output register.
// A stalled output freezes the whole pipeline. After reset and after every
// configuration write, in_ready stays low while the ramp time and cruise end are
// recomputed one quotient bit per cycle and the cruise slope is derived from them.
module joint_motion_profile_position
    import jmpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    cfg_t cfg;
    logic advance;

    jmpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic out_valid_reg;
    out_item_t out_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance && !cfg.busy;

    // entry: segment decision and clamped operands
    logic              t_neg;
    logic [TIME_W-1:0] tu;
    logic [MAG_W:0]    tu_m;
    logic [MAG_W:0]    ts_full;
    logic [MAG_W+1:0]  w_full;
    logic [1:0]        seg_in;
    logic [NUM_W-1:0]  numer;
    side_t             side_in;

    assign t_neg   = in_data.sample_time[WORD_BITS-1];
    assign tu      = in_data.sample_time[TIME_W-1:0];
    assign tu_m    = (MAG_W + 1)'(tu);
    assign ts_full = tu_m - (MAG_W + 1)'(cfg.tc >> 1);
    assign w_full  = (MAG_W + 2)'(cfg.tf2) - (MAG_W + 2)'(tu);
    assign numer   = t_neg ? '0 : (NUM_W'(tu) << FRAC_BITS);

    always_comb
    begin
        seg_in = SEG_HOLD;
        if (t_neg)
            seg_in = SEG_HOLD;
        else if (cfg.tri_mode)
        begin
            if (tu < cfg.switch_time)
                seg_in = SEG_ACCEL;
            else if (tu <= cfg.final_time)
                seg_in = SEG_DECEL;
        end
        else if (cfg.move_distance != '0)
        begin
            if (tu_m < (MAG_W + 1)'(cfg.tc))
                seg_in = SEG_ACCEL;
            else if (tu_m <= (MAG_W + 1)'(cfg.q2))
                seg_in = SEG_CRUISE;
            else if (tu_m <= cfg.tf2)
                seg_in = SEG_DECEL;
        end

        side_in.hold     = in_data.hold_position;
        side_in.seg      = seg_in;
        side_in.tri_mode = cfg.tri_mode;
        side_in.t_sq     = (tu >= TIME_W'(SQ_LIM)) ? SQ_LIM : tu[SQB:0];
        side_in.ts       = ts_full[MAG_W] ? '0 : ts_full[TIME_W-1:0];
        if (w_full[MAG_W+1])
            side_in.w_sq = '0;
        else if (w_full > (MAG_W + 2)'(SQ_LIM))
            side_in.w_sq = SQ_LIM;
        else
            side_in.w_sq = w_full[SQB:0];
    end

    logic             dv_valid;
    logic [MAG_W-1:0] u_q;
    side_t            dv_side;

    jmpp_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid && in_ready),
        .numer     (numer),
        .divisor   (cfg.final_time),
        .in_side   (side_in),
        .out_valid (dv_valid),
        .quotient  (u_q),
        .out_side  (dv_side)
    );

    // stage a: squares and cruise product
    logic [SQB:0]       u_sq;
    logic [FRAC_BITS:0] u_cl;
    assign u_sq = (u_q >= MAG_W'(SQ_LIM)) ? SQ_LIM : u_q[SQB:0];
    assign u_cl = (u_q >= MAG_W'(ONE_Q)) ? ONE_Q : u_q[FRAC_BITS:0];

    logic               a_valid_reg;
    side_t              a_side_reg;
    logic [MAG_W-1:0]   a_uu_reg, a_uc2_reg, a_tt_reg, a_ww_reg, a_kt_reg;
    logic [FRAC_BITS:0] a_ucl_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_side_reg <= dv_side;
            a_ucl_reg  <= u_cl;
            a_uu_reg   <= mul_sat((MAG_W + 1)'(u_sq), (MAG_W + 1)'(u_sq));
            a_uc2_reg  <= mul_sat((MAG_W + 1)'(u_cl), (MAG_W + 1)'(u_cl));
            a_tt_reg   <= mul_sat((MAG_W + 1)'(dv_side.t_sq), (MAG_W + 1)'(dv_side.t_sq));
            a_ww_reg   <= mul_sat((MAG_W + 1)'(dv_side.w_sq), (MAG_W + 1)'(dv_side.w_sq));
            a_kt_reg   <= mul_sat((MAG_W + 1)'(cfg.k_cruise), (MAG_W + 1)'(dv_side.ts));
        end
    end

    // stage b: products with acceleration and distance, deceleration factor
    logic [WORD_BITS-1:0] d_mag;
    logic                 d_neg;
    logic [F_W-1:0]       f_raw;
    assign d_mag = umag(cfg.move_distance);
    assign d_neg = cfg.move_distance[WORD_BITS-1];
    assign f_raw = (F_W'(a_ucl_reg) << 2) - (F_W'(a_uc2_reg) << 1) - F_W'(ONE_Q);

    logic             b_valid_reg;
    side_t            b_side_reg;
    logic [MAG_W-1:0] b_ta_reg, b_tw_reg, b_tria_reg, b_kt_reg;
    logic             b_fneg_reg;
    logic [F_W-1:0]   b_fmag_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_side_reg <= a_side_reg;
            b_kt_reg   <= a_kt_reg;
            b_ta_reg   <= mul_sat((MAG_W + 1)'(a_tt_reg), (MAG_W + 1)'(cfg.accel_max)) >> 1;
            b_tw_reg   <= mul_sat((MAG_W + 1)'(a_ww_reg), (MAG_W + 1)'(cfg.accel_max)) >> 1;
            b_tria_reg <= mul_sat((MAG_W + 1)'(a_uu_reg) << 1, (MAG_W + 1)'(d_mag));
            b_fneg_reg <= f_raw[F_W-1];
            b_fmag_reg <= f_raw[F_W-1] ? F_W'(-f_raw) : f_raw;
        end
    end

    // stage c: last product and choice of base, sign and magnitude
    logic [MAG_W-1:0]            m_trid;
    logic signed [WORD_BITS-1:0] c_base;
    logic                        c_neg;
    logic [MAG_W-1:0]            c_mag;
    assign m_trid = mul_sat((MAG_W + 1)'(b_fmag_reg), (MAG_W + 1)'(d_mag));

    always_comb
    begin
        c_base = b_side_reg.hold;
        c_neg  = 1'b0;
        c_mag  = '0;
        case (b_side_reg.seg)
            SEG_ACCEL:
            begin
                c_base = cfg.start_position;
                c_neg  = d_neg;
                c_mag  = b_side_reg.tri_mode ? b_tria_reg : b_ta_reg;
            end
            SEG_CRUISE:
            begin
                c_base = cfg.start_position;
                c_neg  = d_neg;
                c_mag  = b_kt_reg;
            end
            SEG_DECEL:
            begin
                if (b_side_reg.tri_mode)
                begin
                    c_base = cfg.start_position;
                    c_neg  = b_fneg_reg ^ d_neg;
                    c_mag  = m_trid;
                end
                else
                begin
                    c_base = cfg.end_position;
                    c_neg  = !d_neg;
                    c_mag  = b_tw_reg;
                end
            end
            default: ;
        endcase
    end

    logic                        c_valid_reg;
    logic [1:0]                  c_seg_reg;
    logic                        c_tri_reg;
    logic signed [WORD_BITS-1:0] c_base_reg;
    logic                        c_neg_reg;
    logic [MAG_W-1:0]            c_mag_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_seg_reg  <= b_side_reg.seg;
            c_tri_reg  <= b_side_reg.tri_mode;
            c_base_reg <= c_base;
            c_neg_reg  <= c_neg;
            c_mag_reg  <= c_mag;
        end
    end

    // output register: signed sum saturated to the word
    logic [SUM_W-1:0] mag_ext, sum;
    out_item_t        out_next;
    assign mag_ext = SUM_W'(c_mag_reg);
    assign sum     = SUM_W'(c_base_reg) + (c_neg_reg ? SUM_W'(-mag_ext) : mag_ext);

    always_comb
    begin
        out_next.segment = c_seg_reg;
        if (!sum[SUM_W-1] && (|sum[SUM_W-2:WORD_BITS-1]))
            out_next.position = {1'b0, {(WORD_BITS-1){1'b1}}};
        else if (sum[SUM_W-1] && !(&sum[SUM_W-2:WORD_BITS-1]))
            out_next.position = {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            out_next.position = sum[WORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= dv_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a configuration write blocks new requests on the following cycle
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready)
        else $error("request accepted during constant recompute");

    // a stalled result holds back the whole pipeline
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request accepted while output stalled");

    // cruising only exists in the trapezoidal profile
    a_cruise_trap: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_seg_reg == SEG_CRUISE) |-> !c_tri_reg)
        else $error("cruise segment in triangular profile");

endmodule

// ----- sv/jmpp_cfg.sv -----
// configuration registers and sequential computation of the profile constants
module jmpp_cfg
    import jmpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data,
    output cfg_t                 cfg
);

    logic signed [WORD_BITS-1:0] start_reg, dist_reg, end_reg;
    logic [TIME_W-1:0]           switch_reg, final_reg, accel_reg, vel_reg;
    logic [MAG_W-1:0]            tc_reg, q2_reg, k_reg;
    logic [MAG_W:0]              tf2_reg;
    logic                        tri_reg;
    cfg_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [REM_W:0]              step;
    logic                        last;
    logic [NUM_W-1:0]            q_done;

    assign last   = (cnt_reg == CNT_W'(NUM_W - 1));
    assign step   = div_try(rem_reg, num_reg[NUM_W-1],
                            (state_reg == CFG_DIV_TC) ? accel_reg : vel_reg);
    assign q_done = {num_reg[NUM_W-2:0], step[REM_W]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CFG_LOAD:   state_next = CFG_DIV_TC;
            CFG_DIV_TC: if (last) state_next = CFG_DIV_Q2;
            CFG_DIV_Q2: if (last) state_next = CFG_FINISH;
            CFG_FINISH: state_next = CFG_IDLE;
            CFG_IDLE:   state_next = CFG_IDLE;
            default:    state_next = CFG_IDLE;
        endcase
        if (cfg_write)
            state_next = CFG_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CFG_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            dist_reg   <= '0;
            end_reg    <= '0;
            switch_reg <= '0;
            final_reg  <= TIME_W'(ONE_Q);
            accel_reg  <= TIME_W'(ONE_Q);
            vel_reg    <= TIME_W'(ONE_Q);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START:  start_reg  <= cfg_data;
                REG_DIST:   dist_reg   <= cfg_data;
                REG_END:    end_reg    <= cfg_data;
                REG_SWITCH: switch_reg <= cfg_data[TIME_W-1:0];
                REG_FINAL:  final_reg  <= cfg_data[TIME_W-1:0];
                REG_ACCEL:  accel_reg  <= cfg_data[TIME_W-1:0];
                REG_VEL:    vel_reg    <= cfg_data[TIME_W-1:0];
                default:    ;
            endcase
        end
    end

    // ramp time and cruise end, one quotient bit per cycle; then cruise slope, end time and mode
    always_ff @(posedge clk)
    begin
        case (state_reg)
            CFG_LOAD:
            begin
                num_reg <= NUM_W'(vel_reg) << FRAC_BITS;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            CFG_DIV_TC:
            begin
                if (last)
                begin
                    tc_reg  <= clamp_q(q_done);
                    num_reg <= NUM_W'(umag(dist_reg)) << FRAC_BITS;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    rem_reg <= step[REM_W-1:0];
                    num_reg <= q_done;
                end
            end
            CFG_DIV_Q2:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                rem_reg <= step[REM_W-1:0];
                num_reg <= q_done;
                if (last)
                    q2_reg <= clamp_q(q_done);
            end
            CFG_FINISH:
            begin
                k_reg   <= mul_sat((MAG_W + 1)'(accel_reg), (MAG_W + 1)'(tc_reg));
                tf2_reg <= (MAG_W + 1)'(tc_reg) + (MAG_W + 1)'(q2_reg);
                tri_reg <= (tc_reg >= MAG_W'(switch_reg));
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cfg.start_position = start_reg;
        cfg.move_distance  = dist_reg;
        cfg.end_position   = end_reg;
        cfg.switch_time    = switch_reg;
        cfg.final_time     = final_reg;
        cfg.accel_max      = accel_reg;
        cfg.vel_max        = vel_reg;
        cfg.tc             = tc_reg;
        cfg.q2             = q2_reg;
        cfg.tf2            = tf2_reg;
        cfg.k_cruise       = k_reg;
        cfg.tri_mode       = tri_reg;
        cfg.busy           = (state_reg != CFG_IDLE);
    end

endmodule

// ----- sv/jmpp_div_pipe.sv -----
// pipelined restoring divider for the normalized sample time, side data alongside
module jmpp_div_pipe
    import jmpp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  numer,
    input  logic [TIME_W-1:0] divisor,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [MAG_W-1:0]  quotient,
    output side_t             out_side
);

    logic             valid_reg [DIV_STAGES];
    logic [NUM_W-1:0] num_reg   [DIV_STAGES];
    logic [REM_W-1:0] rem_reg   [DIV_STAGES];
    side_t            side_reg  [DIV_STAGES];
    logic [NUM_W-1:0] num_src   [DIV_STAGES];
    logic [REM_W-1:0] rem_src   [DIV_STAGES];
    logic [NUM_W-1:0] num_next  [DIV_STAGES];
    logic [REM_W-1:0] rem_next  [DIV_STAGES];

    assign num_src[0] = numer;
    assign rem_src[0] = '0;

    for (genvar g = 1; g < DIV_STAGES; g++)
    begin : g_src
        assign num_src[g] = num_reg[g-1];
        assign rem_src[g] = rem_reg[g-1];
    end

    // quotient bits shift in where numerator bits shift out
    always_comb
    begin
        logic [NUM_W-1:0] n;
        logic [REM_W-1:0] r;
        logic [REM_W:0]   s;
        for (int g = 0; g < DIV_STAGES; g++)
        begin
            n = num_src[g];
            r = rem_src[g];
            for (int k = 0; k < DIV_STEP; k++)
            begin
                s = div_try(r, n[NUM_W-1], divisor);
                r = s[REM_W-1:0];
                n = {n[NUM_W-2:0], s[REM_W]};
            end
            num_next[g] = n;
            rem_next[g] = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < DIV_STAGES; g++)
                valid_reg[g] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int g = 1; g < DIV_STAGES; g++)
                valid_reg[g] <= valid_reg[g-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= in_side;
            for (int g = 1; g < DIV_STAGES; g++)
                side_reg[g] <= side_reg[g-1];
            for (int g = 0; g < DIV_STAGES; g++)
            begin
                num_reg[g] <= num_next[g];
                rem_reg[g] <= rem_next[g];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quotient  = clamp_q(num_reg[DIV_STAGES-1]);
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ----- tb/jmpp_checker.sv -----
// position profile checker: follows the register writes, predicts every request and compares
module jmpp_checker
    import jmpp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data,
    output int                   failures,
    output int                   pending
);

    localparam longint SAT_MAG = longint'(BIGV);
    localparam longint ONE_FX  = longint'(ONE_Q);

    logic signed [WORD_BITS-1:0] start_pos, move_dist, end_pos;
    logic [TIME_W-1:0]           t_switch, t_final, acc_max, spd_max;
    out_item_t                   expected_q[$];

    // (a*b) >> FRAC_BITS on magnitudes, clipped
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        p = p >> FRAC_BITS;
        if (p > 128'(SAT_MAG))
            return SAT_MAG;
        return longint'(p[63:0]);
    endfunction

    // (a << FRAC_BITS) / b on magnitudes, clipped, zero divisor clips too
    function automatic longint fx_div(input longint a, input longint b);
        logic [127:0] q;
        if (b == 0)
            return SAT_MAG;
        q = (128'(a) << FRAC_BITS) / 128'(b);
        if (q > 128'(SAT_MAG))
            return SAT_MAG;
        return longint'(q[63:0]);
    endfunction

    function automatic longint fx_smul(input longint x, input longint y);
        longint m;
        m = fx_mul(x < 0 ? -x : x, y < 0 ? -y : y);
        return ((x < 0) != (y < 0)) ? -m : m;
    endfunction

    function automatic out_item_t profile_position(input in_item_t req);
        longint    t, s, d, e, tm, tf, tc, u, u2, f, tf2, mag, pos;
        out_item_t r;
        t   = longint'(req.sample_time);
        s   = longint'(start_pos);
        d   = longint'(move_dist);
        e   = longint'(end_pos);
        tm  = longint'(t_switch);
        tf  = longint'(t_final);
        tc  = fx_div(longint'(spd_max), longint'(acc_max));
        pos = longint'(req.hold_position);
        r.segment = SEG_HOLD;
        if (t < 0)
        begin
            // before the move: hold
        end
        else if (tc >= tm)
        begin
            u = fx_div(t, tf);
            if (t < tm)
            begin
                u2 = fx_mul(u, u);
                pos = s + fx_smul(2 * u2, d);
                r.segment = SEG_ACCEL;
            end
            else if (t <= tf)
            begin
                if (u > ONE_FX)
                    u = ONE_FX;
                u2 = fx_mul(u, u);
                f = -ONE_FX + 4 * u - 2 * u2;
                pos = s + fx_smul(f, d);
                r.segment = SEG_DECEL;
            end
        end
        else if (d != 0)
        begin
            tf2 = tc + fx_div(d < 0 ? -d : d, longint'(spd_max));
            if (t < tc)
            begin
                mag = fx_mul(fx_mul(t, t), longint'(acc_max)) >>> 1;
                pos = d > 0 ? s + mag : s - mag;
                r.segment = SEG_ACCEL;
            end
            else if (t <= tf2 - tc)
            begin
                mag = fx_mul(fx_mul(longint'(acc_max), tc), t - (tc >>> 1));
                pos = d > 0 ? s + mag : s - mag;
                r.segment = SEG_CRUISE;
            end
            else if (t <= tf2)
            begin
                mag = fx_mul(fx_mul(tf2 - t, tf2 - t), longint'(acc_max)) >>> 1;
                pos = d > 0 ? e - mag : e + mag;
                r.segment = SEG_DECEL;
            end
        end
        if (pos > 64'sh7fffffff)
            pos = 64'sh7fffffff;
        else if (pos < -64'sh80000000)
            pos = -64'sh80000000;
        r.position = pos[WORD_BITS-1:0];
        return r;
    endfunction

    task automatic report(input string what, input out_item_t got, input out_item_t want);
        $display("mismatch %s: got pos %0d seg %0d, want pos %0d seg %0d at %0t",
                 what, got.position, got.segment, want.position, want.segment, $realtime);
        failures++;
    endtask

    initial failures = 0;
    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos <= '0;
            move_dist <= '0;
            end_pos   <= '0;
            t_switch  <= '0;
            t_final   <= TIME_W'(65536);
            acc_max   <= TIME_W'(65536);
            spd_max   <= TIME_W'(65536);
            expected_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(profile_position(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected result", out_data, '0);
                else
                begin
                    out_item_t want;
                    want = expected_q.pop_front();
                    if (out_data.position !== want.position)
                        report("position", out_data, want);
                    if (out_data.segment !== want.segment)
                        report("segment", out_data, want);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_START:  start_pos <= cfg_data;
                    REG_DIST:   move_dist <= cfg_data;
                    REG_END:    end_pos   <= cfg_data;
                    REG_SWITCH: t_switch  <= cfg_data[TIME_W-1:0];
                    REG_FINAL:  t_final   <= cfg_data[TIME_W-1:0];
                    REG_ACCEL:  acc_max   <= cfg_data[TIME_W-1:0];
                    REG_VEL:    spd_max   <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- tb/joint_motion_profile_position_tb.sv -----
// testbench top: clock, reset, profile settings and sample stimulus for the position block
module joint_motion_profile_position_tb;
    import jmpp_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_START;
    logic [WORD_BITS-1:0] cfg_data = '0;
    int                   failures;
    int                   pending;

    // stimulus side copy of the settings, only used to aim sample times
    longint sw_v = 0, fin_v = 65536, acc_v = 65536, vel_v = 65536, dist_v = 0;
    bit     tx_busy = 1'b1, rx_busy = 1'b1, hold_off_req = 1'b0;

    joint_motion_profile_position dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    jmpp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    always #4 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL joint_motion_profile_position");
        $finish;
    end

    // result side: random stalls, quiet stretches and one long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = 300;
                out_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if (out_ready && out_valid)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_busy = !rx_busy;
                stall = rx_busy ? $urandom_range(0, 9) : 0;
                out_ready <= (stall == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_profile(input logic [31:0] s, input logic [31:0] d, input logic [31:0] e,
                               input logic [31:0] sw, input logic [31:0] fin,
                               input logic [31:0] acc, input logic [31:0] vel);
        // block must be drained before touching the registers
        wait (pending == 0);
        repeat (40) @(posedge clk);
        write_reg(REG_START, s);
        write_reg(REG_DIST, d);
        write_reg(REG_END, e);
        write_reg(REG_SWITCH, sw);
        write_reg(REG_FINAL, fin);
        write_reg(REG_ACCEL, acc);
        write_reg(REG_VEL, vel);
        cfg_write <= 1'b0;
        sw_v   = longint'(sw[30:0]);
        fin_v  = longint'(fin[30:0]);
        acc_v  = longint'(acc[30:0]);
        vel_v  = longint'(vel[30:0]);
        dist_v = longint'(signed'(d));
    endtask

    task automatic send_request(input logic [31:0] t, input logic [31:0] hold);
        int gap;
        if ($urandom_range(0, 49) == 0)
            tx_busy = !tx_busy;
        gap = tx_busy ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.sample_time   <= t;
        in_data.hold_position <= hold;
        @(posedge clk iff (in_valid && in_ready));
    endtask

    task automatic run_phase(input int count);
        longint tc, horizon, tf2;
        longint marks[14];
        logic [31:0] t;
        int k;
        tc  = acc_v == 0 ? 64'h4_0000_0000 : (vel_v << 16) / acc_v;
        tf2 = tc + (vel_v == 0 ? 64'h4_0000_0000
                   : ((dist_v < 0 ? -dist_v : dist_v) << 16) / vel_v);
        horizon = tc >= sw_v ? fin_v : tf2;
        if (horizon > 64'h7000_0000)
            horizon = 64'h7000_0000;
        if (horizon < 16)
            horizon = 16;
        marks = '{0, -1, 64'hffff_ffff_8000_0000, 64'h7fff_ffff, sw_v - 1, sw_v,
                  fin_v, fin_v + 1, tc - 1, tc, tf2 - tc, tf2 - tc + 1, tf2, tf2 + 1};
        // boundary samples first, with extreme hold positions
        for (k = 0; k < 14; k++)
            send_request(marks[k][31:0], k[0] ? 32'h8000_0000 : 32'h7fff_ffff);
        for (k = 14; k < count; k++)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                t = $urandom;
            else if (pick < 25)
                t = marks[$urandom_range(0, 13)][31:0] + $urandom_range(0, 2) - 1;
            else
                t = $urandom_range(0, 32'(horizon + horizon / 8));
            send_request(t, $urandom);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int p;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset settings
        run_phase(60);
        // triangular: ramp time of 4 s beyond the 1 s switch time
        set_profile(32'(10 << 16), 32'(5 << 16), 32'(15 << 16), 32'(1 << 16), 32'(2 << 16),
                    32'(1 << 16), 32'(4 << 16));
        run_phase(70);
        // trapezoidal forward, with a long result hold-off
        set_profile(-32'(1 << 16), 32'(3 << 16), 32'(2 << 16), 32'(2 << 16), 32'(4 << 16),
                    32'(2 << 16), 32'(1 << 16));
        hold_off_req = 1'b1;
        run_phase(70);
        // trapezoidal backward
        set_profile(32'(7 << 16), -32'(6 << 16), 32'(1 << 16), 32'(3 << 16), 32'(4 << 16),
                    32'(3 << 16), 32'(2 << 16));
        run_phase(60);
        // trapezoidal with no travel
        set_profile(32'(5 << 16), 32'd0, 32'(5 << 16), 32'(3 << 16), 32'(4 << 16),
                    32'(3 << 16), 32'(2 << 16));
        run_phase(50);
        // register extremes
        set_profile(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'd1);
        run_phase(50);
        set_profile(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'd1,
                    32'd1, 32'h7fff_ffff);
        run_phase(40);
        // zero divisors
        set_profile(32'(2 << 16), 32'(4 << 16), 32'(6 << 16), 32'(1 << 16), 32'(2 << 16),
                    32'd0, 32'(1 << 16));
        run_phase(40);
        set_profile(32'(2 << 16), -32'(4 << 16), 32'(6 << 16), 32'(1 << 16), 32'(2 << 16),
                    32'(1 << 16), 32'd0);
        run_phase(40);
        set_profile(32'(2 << 16), 32'(4 << 16), 32'(6 << 16), 32'(8 << 16), 32'd0,
                    32'(1 << 16), 32'(1 << 16));
        run_phase(40);
        // random profiles, the last ones with fully random registers
        for (p = 0; p < 6; p++)
        begin
            if (p < 4)
            begin
                logic [31:0] sw;
                sw = $urandom_range(0, 4 << 16);
                set_profile($urandom, $urandom_range(0, 40 << 16) - (20 << 16), $urandom, sw,
                            p[0] ? 2 * sw + 1 : $urandom_range(1, 8 << 16),
                            $urandom_range(1 << 12, 8 << 16), $urandom_range(1 << 12, 8 << 16));
            end
            else
                set_profile($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            run_phase(45);
        end
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("PASS joint_motion_profile_position");
        else
            $display("FAIL joint_motion_profile_position");
        $finish;
    end

endmodule

// ----- joint_motion_profile_position.f -----
sv/jmpp_pkg.sv
sv/jmpp_cfg.sv
sv/jmpp_div_pipe.sv
sv/joint_motion_profile_position.sv
tb/jmpp_checker.sv
tb/joint_motion_profile_position_tb.sv
